[hdl/palette_zoom_remap_defines.svh]
// Assertion macros shared by the checker of the palette remap block.
`ifndef PALETTE_ZOOM_REMAP_DEFINES_SVH
`define PALETTE_ZOOM_REMAP_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define PZR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("palette remap check failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define PZR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("palette remap check failed");

`endif

[hdl/pzr_pkg.sv]
// Package with the widths, codes, types and the reciprocal table of the palette remap block.
`default_nettype none

package pzr_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int SCREEN_WIDTH      = 4096;
    localparam int SCREEN_HEIGHT     = 4096;
    localparam int SOURCE_DIM        = 16384;

    localparam int ACT_W      = 2;
    localparam int COORD_W    = 12;
    localparam int IDX_W      = 8;
    localparam int RGB_W      = 24;
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 28;
    localparam int WIN_W      = 24;
    localparam int ORIGIN_W   = 28;
    localparam int SRC_W      = 14;
    localparam int STRIDE_W   = 15;
    localparam int ZOOM_W     = 6;
    localparam int FLIP_W     = 2;
    localparam int FACT_W     = 5;
    localparam int RECIP_W    = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int LINE_W     = 18;
    localparam int PROD_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;

    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE  = 2'd0,
        ACT_LOCATE = 2'd1,
        ACT_COLOUR = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COL_WIN = 3'd0,
        REG_ROW_WIN = 3'd1,
        REG_ORIGIN  = 3'd2,
        REG_STRIDE  = 3'd3,
        REG_ZOOM    = 3'd4,
        REG_FLIP    = 3'd5,
        REG_BG      = 3'd6
    } cfg_reg_t;

    // Settings in the form the datapath uses them, already saturated.
    typedef struct packed {
        logic [COORD_W-1:0]  xs;
        logic [COORD_W-1:0]  xe;
        logic [COORD_W-1:0]  ys;
        logic [COORD_W-1:0]  ye;
        logic [FACT_W-1:0]   dec;
        logic [RECIP_W-1:0]  recip;
        logic [SRC_W-1:0]    bcol;
        logic [SRC_W-1:0]    brow;
        logic                flip_x;
        logic                flip_y;
        logic [STRIDE_W-1:0] stride;
        logic [RGB_W-1:0]    bg;
    } cfg_t;

    // ceil(2^16 / d): a 12-bit offset times this, shifted down by 16, is the exact quotient.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [FACT_W-1:0] d);
        logic [RECIP_W-1:0] m;
        case (d)
            5'd2:    m = 17'd32768;
            5'd3:    m = 17'd21846;
            5'd4:    m = 17'd16384;
            5'd5:    m = 17'd13108;
            5'd6:    m = 17'd10923;
            5'd7:    m = 17'd9363;
            5'd8:    m = 17'd8192;
            5'd9:    m = 17'd7282;
            5'd10:   m = 17'd6554;
            5'd11:   m = 17'd5958;
            5'd12:   m = 17'd5462;
            5'd13:   m = 17'd5042;
            5'd14:   m = 17'd4682;
            5'd15:   m = 17'd4370;
            5'd16:   m = 17'd4096;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[hdl/pzr_in_if.sv]
// Request channel of the palette remap block: valid, ready and the pixel request fields.
`default_nettype none

interface pzr_in_if import pzr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [IDX_W-1:0]   index;
    logic [RGB_W-1:0]   colour_value;

    modport source (
        output valid,
        output action,
        output out_x,
        output out_y,
        output index,
        output colour_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  out_x,
        input  out_y,
        input  index,
        input  colour_value,
        output ready
    );
endinterface

`default_nettype wire

[hdl/pzr_out_if.sv]
// Result channel of the palette remap block: valid, ready and the result fields.
`default_nettype none

interface pzr_out_if import pzr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              inside_res;
    logic [ADDR_W-1:0] source_address;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;

    modport source (
        output valid,
        output inside_res,
        output source_address,
        output red,
        output green,
        output blue,
        input  ready
    );

    modport sink (
        input  valid,
        input  inside_res,
        input  source_address,
        input  red,
        input  green,
        input  blue,
        output ready
    );
endinterface

`default_nettype wire

[hdl/pzr_cfg.sv]
// Configuration registers of the palette remap block and the saturated settings derived from them.
`default_nettype none

module pzr_cfg import pzr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    localparam logic signed [ZOOM_W-1:0] ZOOM_HI  = 6'sd16;
    localparam logic signed [ZOOM_W-1:0] ZOOM_LO  = -6'sd16;
    localparam logic signed [ZOOM_W-1:0] ZOOM_ONE = 6'sd1;
    localparam logic signed [ZOOM_W-1:0] ZOOM_NEG_ONE = -6'sd1;
    localparam logic signed [ZOOM_W-1:0] ZOOM_ZERO = 6'sd0;

    logic [WIN_W-1:0]    col_win_reg, col_win_next;
    logic [WIN_W-1:0]    row_win_reg, row_win_next;
    logic [ORIGIN_W-1:0] origin_reg, origin_next;
    logic [STRIDE_W-1:0] stride_reg, stride_next;
    logic [ZOOM_W-1:0]   zoom_reg, zoom_next;
    logic [FLIP_W-1:0]   flip_reg, flip_next;
    logic [RGB_W-1:0]    bg_reg, bg_next;

    logic signed [ZOOM_W-1:0] zoom_sat;
    logic signed [ZOOM_W-1:0] zoom_neg;
    logic [FACT_W-1:0]        rep;
    logic [SRC_W-1:0]         col_clamp;
    logic [SRC_W-1:0]         row_clamp;

    always_comb
    begin
        col_win_next = col_win_reg;
        row_win_next = row_win_reg;
        origin_next  = origin_reg;
        stride_next  = stride_reg;
        zoom_next    = zoom_reg;
        flip_next    = flip_reg;
        bg_next      = bg_reg;
        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_COL_WIN: col_win_next = cfg_data[WIN_W-1:0];
                REG_ROW_WIN: row_win_next = cfg_data[WIN_W-1:0];
                REG_ORIGIN:  origin_next  = cfg_data[ORIGIN_W-1:0];
                REG_STRIDE:  stride_next  = cfg_data[STRIDE_W-1:0];
                REG_ZOOM:    zoom_next    = cfg_data[ZOOM_W-1:0];
                REG_FLIP:    flip_next    = cfg_data[FLIP_W-1:0];
                REG_BG:      bg_next      = cfg_data[RGB_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_win_reg <= '0;
            row_win_reg <= '0;
            origin_reg  <= '0;
            stride_reg  <= STRIDE_W'(1);
            zoom_reg    <= ZOOM_W'(1);
            flip_reg    <= '0;
            bg_reg      <= '0;
        end
        else
        begin
            col_win_reg <= col_win_next;
            row_win_reg <= row_win_next;
            origin_reg  <= origin_next;
            stride_reg  <= stride_next;
            zoom_reg    <= zoom_next;
            flip_reg    <= flip_next;
            bg_reg      <= bg_next;
        end
    end

    always_comb
    begin
        zoom_sat = signed'(zoom_reg);
        if (zoom_sat > ZOOM_HI)
            zoom_sat = ZOOM_HI;
        else if (zoom_sat < ZOOM_LO)
            zoom_sat = ZOOM_LO;
        if (zoom_sat == ZOOM_ZERO || zoom_sat == ZOOM_NEG_ONE)
            zoom_sat = ZOOM_ONE;
        zoom_neg = -zoom_sat;
        rep      = (zoom_sat > ZOOM_ZERO) ? zoom_sat[FACT_W-1:0] : FACT_W'(1);

        cfg.dec   = (zoom_sat < ZOOM_ZERO) ? zoom_neg[FACT_W-1:0] : FACT_W'(1);
        cfg.recip = recip_of(rep);

        cfg.xs = col_win_reg[COORD_W-1:0];
        cfg.xe = col_win_reg[2*COORD_W-1:COORD_W];
        cfg.ys = row_win_reg[COORD_W-1:0];
        cfg.ye = row_win_reg[2*COORD_W-1:COORD_W];

        if (stride_reg == '0)
            cfg.stride = STRIDE_W'(1);
        else if ({1'b0, stride_reg} > (STRIDE_W+1)'(SOURCE_DIM))
            cfg.stride = STRIDE_W'(SOURCE_DIM);
        else
            cfg.stride = stride_reg;

        col_clamp = ({1'b0, origin_reg[SRC_W-1:0]} > (SRC_W+1)'(SOURCE_DIM - 1)) ?
                    SRC_W'(SOURCE_DIM - 1) : origin_reg[SRC_W-1:0];
        row_clamp = ({1'b0, origin_reg[2*SRC_W-1:SRC_W]} > (SRC_W+1)'(SOURCE_DIM - 1)) ?
                    SRC_W'(SOURCE_DIM - 1) : origin_reg[2*SRC_W-1:SRC_W];

        // A flipped axis starts one sample back, but never below zero.
        cfg.flip_x = flip_reg[0];
        cfg.flip_y = flip_reg[1];
        cfg.bcol   = (flip_reg[0] && col_clamp != '0) ? col_clamp - SRC_W'(1) : col_clamp;
        cfg.brow   = (flip_reg[1] && row_clamp != '0) ? row_clamp - SRC_W'(1) : row_clamp;

        cfg.bg = bg_reg;
    end

endmodule

`default_nettype wire

[hdl/pzr_palette.sv]
// Palette memory of the palette remap block: one write port and one registered read port.
`default_nettype none

module pzr_palette import pzr_pkg::*; #(
    parameter int DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [RGB_W-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [RGB_W-1:0]         rd_data
);

    logic [RGB_W-1:0] mem [DEPTH];
    logic [RGB_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/pzr_pipe.sv]
// Five-stage datapath of the palette remap block: window test, zoom divide, offsets, row product, sum.
`default_nettype none

module pzr_pipe import pzr_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             index_ok,
    input  logic [RGB_W-1:0] pal_data,
    pzr_in_if.sink           req,
    pzr_out_if.source        rsp
);

    localparam int STAGES = 5;
    localparam int DIV_W  = COORD_W + RECIP_W;
    localparam int STEP_W = COORD_W + FACT_W;
    localparam int FULL_W = LINE_W + STRIDE_W + 1;
    localparam int SUM_W  = PROD_W + 1;

    typedef struct packed {
        action_t            act;
        logic               in_win;
        logic               ok;
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
    } s1_t;

    typedef struct packed {
        action_t            act;
        logic               in_win;
        logic               ok;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic [RGB_W-1:0]   rgb;
    } s2_t;

    typedef struct packed {
        action_t           act;
        logic              in_win;
        logic              ok;
        logic [LINE_W-1:0] row;
        logic [LINE_W-1:0] col;
        logic [RGB_W-1:0]  rgb;
    } s3_t;

    typedef struct packed {
        action_t           act;
        logic              in_win;
        logic              ok;
        logic [PROD_W-1:0] prod;
        logic [LINE_W-1:0] col;
        logic [RGB_W-1:0]  rgb;
    } s4_t;

    typedef struct packed {
        logic              in_win;
        logic [ADDR_W-1:0] addr;
        logic [RGB_W-1:0]  rgb;
    } s5_t;

    logic [STAGES-1:0] valid_reg, valid_next;
    logic [STAGES-1:0] adv;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;

    // A stage moves when it is empty or the stage after it moves.
    always_comb
    begin
        adv[4] = !valid_reg[4] || rsp.ready;
        adv[3] = !valid_reg[3] || adv[4];
        adv[2] = !valid_reg[2] || adv[3];
        adv[1] = !valid_reg[1] || adv[2];
        adv[0] = !valid_reg[0] || adv[1];

        valid_next[0] = adv[0] ? req.valid : valid_reg[0];
        valid_next[1] = adv[1] ? valid_reg[0] : valid_reg[1];
        valid_next[2] = adv[2] ? valid_reg[1] : valid_reg[2];
        valid_next[3] = adv[3] ? valid_reg[2] : valid_reg[3];
        valid_next[4] = adv[4] ? valid_reg[3] : valid_reg[4];
    end

    assign req.ready = adv[0];

    // Stage 1: window test and offsets from the window start.
    always_comb
    begin
        logic in_x;
        logic in_y;
        logic mapped;
        in_x = (req.out_x >= cfg.xs) && (req.out_x < cfg.xe) &&
               ({1'b0, req.out_x} < (COORD_W+1)'(SCREEN_WIDTH));
        in_y = (req.out_y >= cfg.ys) && (req.out_y < cfg.ye) &&
               ({1'b0, req.out_y} < (COORD_W+1)'(SCREEN_HEIGHT));
        s1_next.act = action_t'(req.action);
        mapped = (s1_next.act == ACT_LOCATE) || (s1_next.act == ACT_COLOUR);
        s1_next.in_win = mapped && in_x && in_y;
        s1_next.ok     = index_ok;
        s1_next.ox     = req.out_x - cfg.xs;
        s1_next.oy     = req.out_y - cfg.ys;
    end

    // Stage 2: divide the offsets by the replication factor through its reciprocal.
    always_comb
    begin
        logic [DIV_W-1:0] qx;
        logic [DIV_W-1:0] qy;
        qx = DIV_W'(s1_reg.ox) * DIV_W'(cfg.recip);
        qy = DIV_W'(s1_reg.oy) * DIV_W'(cfg.recip);
        s2_next.act    = s1_reg.act;
        s2_next.in_win = s1_reg.in_win;
        s2_next.ok     = s1_reg.ok;
        s2_next.bx     = qx[RECIP_SHIFT +: COORD_W];
        s2_next.by     = qy[RECIP_SHIFT +: COORD_W];
        s2_next.rgb    = pal_data;
    end

    // Stage 3: scale by the decimation step and move from the origin in the flip direction.
    always_comb
    begin
        logic [STEP_W-1:0]        step_x;
        logic [STEP_W-1:0]        step_y;
        logic signed [LINE_W-1:0] base_c;
        logic signed [LINE_W-1:0] base_r;
        logic signed [LINE_W-1:0] dx;
        logic signed [LINE_W-1:0] dy;
        step_x = STEP_W'(s2_reg.bx) * STEP_W'(cfg.dec);
        step_y = STEP_W'(s2_reg.by) * STEP_W'(cfg.dec);
        base_c = signed'(LINE_W'(cfg.bcol));
        base_r = signed'(LINE_W'(cfg.brow));
        dx     = signed'(LINE_W'(step_x));
        dy     = signed'(LINE_W'(step_y));
        s3_next.act    = s2_reg.act;
        s3_next.in_win = s2_reg.in_win;
        s3_next.ok     = s2_reg.ok;
        s3_next.col    = cfg.flip_x ? base_c - dx : base_c + dx;
        s3_next.row    = cfg.flip_y ? base_r - dy : base_r + dy;
        s3_next.rgb    = s2_reg.rgb;
    end

    // Stage 4: source row times stride.
    always_comb
    begin
        logic signed [LINE_W-1:0]   row_s;
        logic signed [STRIDE_W:0]   stride_s;
        logic signed [FULL_W-1:0]   full;
        row_s    = signed'(s3_reg.row);
        stride_s = signed'({1'b0, cfg.stride});
        full     = row_s * stride_s;
        s4_next.act    = s3_reg.act;
        s4_next.in_win = s3_reg.in_win;
        s4_next.ok     = s3_reg.ok;
        s4_next.prod   = full[PROD_W-1:0];
        s4_next.col    = s3_reg.col;
        s4_next.rgb    = s3_reg.rgb;
    end

    // Stage 5: add the column, saturate and pick the colour.
    always_comb
    begin
        logic signed [PROD_W-1:0] p;
        logic signed [LINE_W-1:0] c;
        logic signed [SUM_W-1:0]  sum;
        logic [ADDR_W-1:0]        addr;
        p   = signed'(s4_reg.prod);
        c   = signed'(s4_reg.col);
        sum = p + c;
        if (sum < 0)
            addr = '0;
        else if (sum > signed'({(SUM_W-ADDR_W)'(0), ADDR_MAX}))
            addr = ADDR_MAX;
        else
            addr = sum[ADDR_W-1:0];
        s5_next.in_win = s4_reg.in_win;
        s5_next.addr   = s4_reg.in_win ? addr : '0;
        if (s4_reg.act == ACT_COLOUR)
            s5_next.rgb = (s4_reg.in_win && s4_reg.ok) ? s4_reg.rgb : cfg.bg;
        else
            s5_next.rgb = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
            s1_reg <= s1_next;
        if (adv[1])
            s2_reg <= s2_next;
        if (adv[2])
            s3_reg <= s3_next;
        if (adv[3])
            s4_reg <= s4_next;
        if (adv[4])
            s5_reg <= s5_next;
    end

    assign rsp.valid          = valid_reg[4];
    assign rsp.inside_res     = s5_reg.in_win;
    assign rsp.source_address = s5_reg.addr;
    assign rsp.red            = s5_reg.rgb[BYTE_W-1:0];
    assign rsp.green          = s5_reg.rgb[2*BYTE_W-1:BYTE_W];
    assign rsp.blue           = s5_reg.rgb[3*BYTE_W-1:2*BYTE_W];

endmodule

`default_nettype wire

[hdl/palette_zoom_remap.sv]
// Top level of the palette remap block: configuration, palette memory and datapath.
//
//   channel     kind        direction  carries
//   pixel_req   valid/ready in         action, out_x, out_y, index, colour_value
//   pixel_rsp   valid/ready out        inside_res, source_address, red, green, blue
//   cfg_*       write only  in         cfg_write, cfg_index, cfg_data
//
// There are five register stages, the first loading at the acceptance edge, and one
// request can enter in every cycle unless a stalled result backs up the stages. The
// palette is read and written at the acceptance edge, so a colour request sees a
// palette write accepted in the cycle before it.
// rst_n clears the settings and the stage valid bits; palette contents stay
// undefined until written. A stalled result holds the full stages right behind it.
`default_nettype none

module palette_zoom_remap import pzr_pkg::*; #(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pzr_in_if.sink                pixel_req,
    pzr_out_if.source             pixel_rsp,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PAL_AW = $clog2(PALETTE_DEPTH);
    localparam int CMP_W  = 17;

    cfg_t              cfg;
    logic              index_ok;
    logic              pal_we;
    logic [PAL_AW-1:0] pal_addr;
    logic [RGB_W-1:0]  pal_data;

    assign index_ok = CMP_W'(pixel_req.index) < CMP_W'(PALETTE_DEPTH);
    assign pal_addr = PAL_AW'(pixel_req.index);
    assign pal_we   = pixel_req.valid && pixel_req.ready && index_ok &&
                      (action_t'(pixel_req.action) == ACT_WRITE);

    pzr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pzr_palette #(
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_we),
        .wr_addr (pal_addr),
        .wr_data (pixel_req.colour_value),
        .rd_en   (pixel_req.ready),
        .rd_addr (pal_addr),
        .rd_data (pal_data)
    );

    pzr_pipe u_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .index_ok (index_ok),
        .pal_data (pal_data),
        .req      (pixel_req),
        .rsp      (pixel_rsp)
    );

endmodule

`default_nettype wire

[hdl/pzr_checker.sv]
// Port-level checker of the palette remap block and its bind to the top level.
`default_nettype none
`include "palette_zoom_remap_defines.svh"

module pzr_checker import pzr_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic              rsp_inside,
    input logic [ADDR_W-1:0] rsp_address,
    input logic [BYTE_W-1:0] rsp_red,
    input logic [BYTE_W-1:0] rsp_green,
    input logic [BYTE_W-1:0] rsp_blue
);

    // A stalled result stays up with its payload unchanged.
    `PZR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_inside) && $stable(rsp_address) && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue))

    // A pixel outside the window never carries a source address.
    `PZR_ASSERT_NOW(a_outside_addr, rsp_valid && !rsp_inside, rsp_address == '0)

    // With the output free to move, the whole pipeline moves and takes a request.
    `PZR_ASSERT_NOW(a_ready_free, !rsp_valid || rsp_ready, req_ready)

endmodule

bind palette_zoom_remap pzr_checker u_pzr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_ready   (pixel_req.ready),
    .rsp_valid   (pixel_rsp.valid),
    .rsp_ready   (pixel_rsp.ready),
    .rsp_inside  (pixel_rsp.inside_res),
    .rsp_address (pixel_rsp.source_address),
    .rsp_red     (pixel_rsp.red),
    .rsp_green   (pixel_rsp.green),
    .rsp_blue    (pixel_rsp.blue)
);

`default_nettype wire
